// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the edge filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kuf_pkg.sv
// Types and constants shared by the union-find edge filter.
package kuf_pkg;

    localparam int VERTEX_W     = 8;
    localparam int WEIGHT_W     = 16;
    localparam int COUNT_W      = 8;
    localparam int TABLE_DEPTH  = 2 ** VERTEX_W;
    localparam int VERTEX_COUNT = 256;

    localparam int Q_PTR_W      = 2;
    localparam int QUEUE_DEPTH  = 2 ** Q_PTR_W;
    localparam logic [Q_PTR_W:0] Q_FULL = (Q_PTR_W + 1)'(QUEUE_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_ONE = (COUNT_W)'(1);

    // One edge as it waits in the queue, with its classification.
    typedef struct packed {
        logic [VERTEX_W-1:0]        vertex_a;
        logic [VERTEX_W-1:0]        vertex_b;
        logic signed [WEIGHT_W-1:0] edge_weight;
        logic                       final_edge;
        logic                       in_range;
        logic                       self_loop;
    } t_edge_cmd;

    // One finished result.
    typedef struct packed {
        logic [VERTEX_W-1:0]        vertex_a;
        logic [VERTEX_W-1:0]        vertex_b;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       taken;
        logic [COUNT_W-1:0]         tree_edges;
        logic                       graph_done;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_DONE
    } t_back_state;

endpackage

// File: rtl/kuf_edge_if.sv
// Channel carrying one edge per beat into the filter.
interface kuf_edge_if;
    logic                                        valid;
    logic                                        ready;
    logic [kuf_pkg::VERTEX_W-1:0]                vertex_a;
    logic [kuf_pkg::VERTEX_W-1:0]                vertex_b;
    logic signed [kuf_pkg::WEIGHT_W-1:0]         edge_weight;
    logic                                        final_edge;

    modport source (output valid, vertex_a, vertex_b, edge_weight, final_edge, input ready);
    modport sink   (input valid, vertex_a, vertex_b, edge_weight, final_edge, output ready);
endinterface

// File: rtl/kuf_result_if.sv
// Channel carrying one filter result per beat out of the filter.
interface kuf_result_if;
    logic                                valid;
    logic                                ready;
    logic [kuf_pkg::VERTEX_W-1:0]        out_vertex_a;
    logic [kuf_pkg::VERTEX_W-1:0]        out_vertex_b;
    logic signed [kuf_pkg::WEIGHT_W-1:0] out_weight;
    logic                                taken;
    logic [kuf_pkg::COUNT_W-1:0]         tree_edges;
    logic                                graph_done;

    modport source (output valid, out_vertex_a, out_vertex_b, out_weight, taken, tree_edges,
                    graph_done, input ready);
    modport sink   (input valid, out_vertex_a, out_vertex_b, out_weight, taken, tree_edges,
                    graph_done, output ready);
endinterface

// File: rtl/kruskal_union_find_edge_filter_core.sv
// Top level of the Kruskal union-find edge filter.
//
//  Channel    Dir  Beat
//  i_edge     in   vertex_a, vertex_b, edge_weight, final_edge
//  o_result   out  out_vertex_a, out_vertex_b, out_weight, taken, tree_edges, graph_done
//
// The back end follows the parent links from each endpoint to its root, one
// link a cycle through the single table read port; an edge with an endpoint out of
// range, or a self loop, skips both walks and goes straight to the done state.
// Reset (i_rst_n low at a clock edge) empties the queue, drops any pending result
// and restores the table to identity at once through per-entry valid bits.
// The four-entry front queue keeps edges flowing in while the back end walks or stalls.
module kruskal_union_find_edge_filter_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kuf_edge_if.sink     i_edge,
    kuf_result_if.source o_result
);

    // Edge commands pass from the front queue to the back end one beat at a
    // time under a valid/ready handshake of their own.
    logic               cmd_valid;
    logic               cmd_ready;
    kuf_pkg::t_edge_cmd cmd;

    // The front end accepts edges, marks those that need no walk (an endpoint
    // outside the vertex range, or both endpoints equal) and queues them.
    kuf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge      (i_edge),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // The back end finds both roots, links the first root to the second when
    // they differ, counts the union and registers the result. When the
    // result for the final edge of a graph is registered, it also resets the
    // table and the count for the next graph.
    kuf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_result    (o_result)
    );

endmodule

// File: rtl/kuf_front.sv
// Front end: accepts edges, classifies them and queues them for the back end.
module kuf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    kuf_edge_if.sink           i_edge,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output kuf_pkg::t_edge_cmd o_cmd
);

    kuf_pkg::t_edge_cmd              r_q [kuf_pkg::QUEUE_DEPTH];
    logic [kuf_pkg::Q_PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [kuf_pkg::Q_PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [kuf_pkg::Q_PTR_W:0]       r_cnt, n_cnt;
    logic                            push, pop;
    kuf_pkg::t_edge_cmd              new_cmd;

    assign i_edge.ready = (r_cnt != kuf_pkg::Q_FULL);
    assign push         = i_edge.valid && i_edge.ready;
    assign o_cmd_valid  = (r_cnt != '0);
    assign pop          = o_cmd_valid && i_cmd_ready;
    assign o_cmd        = r_q[r_rd_ptr];

    // An edge with an endpoint outside the vertex range is ignored, and a
    // self loop can never join two sets, so neither needs a walk.
    always_comb begin
        new_cmd.vertex_a    = i_edge.vertex_a;
        new_cmd.vertex_b    = i_edge.vertex_b;
        new_cmd.edge_weight = i_edge.edge_weight;
        new_cmd.final_edge  = i_edge.final_edge;
        new_cmd.in_range    = (32'(i_edge.vertex_a) < kuf_pkg::VERTEX_COUNT) &&
                              (32'(i_edge.vertex_b) < kuf_pkg::VERTEX_COUNT);
        new_cmd.self_loop   = (i_edge.vertex_a == i_edge.vertex_b);
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_cmd;
        end
    end

endmodule

// File: rtl/kuf_back.sv
// Back end: walks the parent table for both endpoints, joins roots, drives results.
`include "assert_macros.svh"

module kuf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  kuf_pkg::t_edge_cmd i_cmd,
    kuf_result_if.source       o_result
);

    // Parent table; an entry whose valid bit is clear reads as its own index.
    logic [kuf_pkg::VERTEX_W-1:0]     r_mem [kuf_pkg::TABLE_DEPTH];
    logic [kuf_pkg::TABLE_DEPTH-1:0]  r_valid;
    logic [kuf_pkg::VERTEX_W-1:0]     r_rd_data;
    logic                             r_rd_valid;

    kuf_pkg::t_back_state             r_state, n_state;
    kuf_pkg::t_edge_cmd               r_cmd, n_cmd;
    logic [kuf_pkg::VERTEX_W-1:0]     r_node, n_node;
    logic [kuf_pkg::VERTEX_W-1:0]     r_root_a, n_root_a;
    logic                             r_take, n_take;
    logic [kuf_pkg::COUNT_W-1:0]      r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    kuf_pkg::t_result                 r_out;

    logic [kuf_pkg::VERTEX_W-1:0]     rd_addr;
    logic [kuf_pkg::VERTEX_W-1:0]     parent;
    logic                             is_root;
    logic                             wr_en;
    logic                             load_out;
    logic                             clear_table;

    assign parent  = r_rd_valid ? r_rd_data : r_node;
    assign is_root = (parent == r_node);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_node      = r_node;
        n_root_a    = r_root_a;
        n_take      = r_take;
        n_count     = r_count;
        rd_addr     = r_node;
        wr_en       = 1'b0;
        load_out    = 1'b0;
        clear_table = 1'b0;
        o_cmd_ready = 1'b0;

        unique case (r_state)
            kuf_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.in_range && !i_cmd.self_loop) begin
                        rd_addr = i_cmd.vertex_a;
                        n_node  = i_cmd.vertex_a;
                        n_state = kuf_pkg::ST_FIND_A;
                    end else begin
                        n_take  = 1'b0;
                        n_state = kuf_pkg::ST_DONE;
                    end
                end
            end
            kuf_pkg::ST_FIND_A: begin
                if (is_root) begin
                    n_root_a = r_node;
                    rd_addr  = r_cmd.vertex_b;
                    n_node   = r_cmd.vertex_b;
                    n_state  = kuf_pkg::ST_FIND_B;
                end else begin
                    rd_addr = parent;
                    n_node  = parent;
                end
            end
            kuf_pkg::ST_FIND_B: begin
                if (is_root) begin
                    n_take  = (r_root_a != r_node);
                    wr_en   = (r_root_a != r_node);
                    if (r_root_a != r_node) begin
                        n_count = r_count + kuf_pkg::COUNT_ONE;
                    end
                    n_state = kuf_pkg::ST_DONE;
                end else begin
                    rd_addr = parent;
                    n_node  = parent;
                end
            end
            kuf_pkg::ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    load_out = 1'b1;
                    if (r_cmd.final_edge) begin
                        clear_table = 1'b1;
                        n_count     = '0;
                    end
                    n_state = kuf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kuf_pkg::ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kuf_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (clear_table) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[r_root_a] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_node     <= n_node;
        r_root_a   <= n_root_a;
        r_take     <= n_take;
        r_rd_valid <= r_valid[rd_addr];
        if (load_out) begin
            r_out.vertex_a   <= r_cmd.vertex_a;
            r_out.vertex_b   <= r_cmd.vertex_b;
            r_out.weight     <= r_cmd.edge_weight;
            r_out.taken      <= r_take;
            r_out.tree_edges <= r_count;
            r_out.graph_done <= r_cmd.final_edge;
        end
    end

    // Table memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_root_a] <= r_node;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_vertex_a = r_out.vertex_a;
    assign o_result.out_vertex_b = r_out.vertex_b;
    assign o_result.out_weight   = r_out.weight;
    assign o_result.taken        = r_out.taken;
    assign o_result.tree_edges   = r_out.tree_edges;
    assign o_result.graph_done   = r_out.graph_done;

    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, wr_en, r_count - $past(r_count) == kuf_pkg::COUNT_ONE, "count did not advance on a union")
    `ASSERT_IMPLIES(a_load_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == kuf_pkg::ST_DONE, "result loaded outside the done state")
    `ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, load_out && r_cmd.final_edge, r_count == '0 && r_valid == '0, "table not restored after the final edge")
    `ASSERT_IMPLIES(a_no_take_skipped, i_clk, i_rst_n, r_state == kuf_pkg::ST_DONE && (!r_cmd.in_range || r_cmd.self_loop), !r_take, "skipped edge marked as taken")

endmodule

// File: verif/tb_kruskal_union_find_edge_filter_core.sv
// Self-checking testbench for the Kruskal union-find edge filter core.
`timescale 1ns / 1ps

module tb_kruskal_union_find_edge_filter_core;

    // Run-length and pacing constants.
    localparam int          N_DIRECTED   = 20;
    localparam int unsigned LONG_HOLD    = 200;   // receiver hold-off under pressure
    localparam int unsigned DRAIN_CYCLES = 600;   // margin beyond the longest parent walk
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned PHASE_A_END  = 700;
    localparam int unsigned PHASE_B_END  = 1600;
    localparam int unsigned TOTAL_ITEMS  = 1900;

    // One edge as the sender offers it.
    typedef struct packed {
        logic [kuf_pkg::VERTEX_W-1:0]        va;
        logic [kuf_pkg::VERTEX_W-1:0]        vb;
        logic signed [kuf_pkg::WEIGHT_W-1:0] w;
        logic                                last;
    } t_edge_beat;

    // A directed row: the edge, and where it is obvious, the verdict typed in by hand.
    typedef struct packed {
        t_edge_beat                  beat;
        logic                        typed;
        logic                        typed_taken;
        logic [kuf_pkg::COUNT_W-1:0] typed_count;
    } t_row;

    // The directed table. Rows with typed set carry a hand-worked verdict; the rest
    // are left to the predictor. Comments give the intent of each group.
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // Fresh table after reset: extremes of the vertex range and of the weight.
        '{'{8'd0,   8'd255, 16'sh7FFF, 1'b0}, 1'b1, 1'b1, 8'd1},
        '{'{8'd255, 8'd0,   16'sh8000, 1'b0}, 1'b1, 1'b0, 8'd1},
        // Self loop is never taken.
        '{'{8'd7,   8'd7,   16'sh0000, 1'b0}, 1'b1, 1'b0, 8'd1},
        // Build 1 -> 2 -> 3, then close the triangle, which must be refused.
        '{'{8'd1,   8'd2,   16'sh0001, 1'b0}, 1'b1, 1'b1, 8'd2},
        '{'{8'd2,   8'd3,   16'sh0002, 1'b0}, 1'b1, 1'b1, 8'd3},
        '{'{8'd3,   8'd1,   16'sh0003, 1'b0}, 1'b1, 1'b0, 8'd3},
        // Alternating bit patterns on every field.
        '{'{8'd170, 8'd85,  16'sh5555, 1'b0}, 1'b1, 1'b1, 8'd4},
        '{'{8'd85,  8'd170, 16'shAAAA, 1'b0}, 1'b1, 1'b0, 8'd4},
        // Final edge: answered with the old table, then the table returns to identity.
        '{'{8'd255, 8'd3,   16'sh0064, 1'b1}, 1'b1, 1'b1, 8'd5},
        '{'{8'd0,   8'd255, 16'sh0064, 1'b0}, 1'b1, 1'b1, 8'd1},
        // Self loop as the final edge, then a graph of a single edge.
        '{'{8'd255, 8'd255, 16'sh0000, 1'b1}, 1'b1, 1'b0, 8'd1},
        '{'{8'd3,   8'd1,   16'sh0005, 1'b1}, 1'b1, 1'b1, 8'd1},
        // A short chain walked from both ends, left to the predictor.
        '{'{8'd10,  8'd11,  16'sh000A, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd11,  8'd12,  16'sh000B, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd12,  8'd13,  16'sh000C, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd13,  8'd14,  16'sh000D, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd10,  8'd14,  16'sh000E, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd20,  8'd10,  16'sh000F, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd14,  8'd20,  16'sh0010, 1'b0}, 1'b0, 1'b0, 8'd0},
        '{'{8'd200, 8'd10,  16'sh0011, 1'b1}, 1'b0, 1'b0, 8'd0}
    };

    logic i_clk;
    logic i_rst_n;

    kuf_edge_if   edge_bus ();
    kuf_result_if res_bus ();

    kruskal_union_find_edge_filter_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_edge   (edge_bus),
        .o_result (res_bus)
    );

    // The predictor's own forest: a parent table and the running count of tree edges.
    logic [kuf_pkg::VERTEX_W-1:0] forest_parent [kuf_pkg::TABLE_DEPTH];
    logic [kuf_pkg::COUNT_W-1:0]  forest_edges;

    // Verdicts waiting for their result beat, oldest first.
    kuf_pkg::t_result pending_verdicts [$];

    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned result_idx;
    bit          idle_on;
    bit          long_hold_req;

    // Clock: 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Safety net: a correct run finishes far inside this window.
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_forest();
        for (int k = 0; k < kuf_pkg::TABLE_DEPTH; k++) begin
            forest_parent[k] = (kuf_pkg::VERTEX_W)'(k);
        end
        forest_edges = '0;
    endfunction

    // Follows parent links until a node points at itself. The step bound is never
    // reached, since unions only ever join two distinct roots.
    function automatic logic [kuf_pkg::VERTEX_W-1:0] find_root(
        input logic [kuf_pkg::VERTEX_W-1:0] v);
        logic [kuf_pkg::VERTEX_W-1:0] node;
        node = v;
        for (int s = 0; s < kuf_pkg::TABLE_DEPTH; s++) begin
            if (forest_parent[node] == node) break;
            node = forest_parent[node];
        end
        return node;
    endfunction

    // Works out the result for one accepted edge and updates the forest. The verdict
    // for a final edge is formed from the current forest before it is cleared.
    function automatic kuf_pkg::t_result kruskal_verdict(input t_edge_beat b);
        kuf_pkg::t_result             r;
        logic [kuf_pkg::VERTEX_W-1:0] ra;
        logic [kuf_pkg::VERTEX_W-1:0] rb;
        r.vertex_a = b.va;
        r.vertex_b = b.vb;
        r.weight   = b.w;
        r.taken    = 1'b0;
        if (int'(b.va) < kuf_pkg::VERTEX_COUNT && int'(b.vb) < kuf_pkg::VERTEX_COUNT) begin
            ra = find_root(b.va);
            rb = find_root(b.vb);
            if (ra != rb) begin
                forest_parent[ra] = rb;
                forest_edges      = forest_edges + kuf_pkg::COUNT_ONE;
                r.taken           = 1'b1;
            end
        end
        r.tree_edges = forest_edges;
        r.graph_done = b.last;
        if (b.last) clear_forest();
        return r;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("result %0d: %s expected %0h, got %0h", result_idx, what, want_v, got_v);
        end
    endtask

    // Offers one edge, optionally after an idle burst, and waits for the handshake.
    // Valid stays high from one beat to the next unless a gap is inserted, so it is
    // never lowered and raised in the same time step.
    task automatic send_edge(input t_edge_beat b, input bit typed, input bit typed_taken,
                             input logic [kuf_pkg::COUNT_W-1:0] typed_count);
        kuf_pkg::t_result v;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            edge_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        edge_bus.valid       <= 1'b1;
        edge_bus.vertex_a    <= b.va;
        edge_bus.vertex_b    <= b.vb;
        edge_bus.edge_weight <= b.w;
        edge_bus.final_edge  <= b.last;
        @(posedge i_clk);
        while (!edge_bus.ready) @(posedge i_clk);
        // The beat was taken at this edge: predict it now so that order is kept.
        v = kruskal_verdict(b);
        if (typed) begin
            v.taken      = typed_taken;
            v.tree_edges = typed_count;
        end
        pending_verdicts.push_back(v);
        items_sent++;
    endtask

    // Sends one random graph. A tidy graph draws its endpoints from a small window
    // of vertices, with nondecreasing weights and the final flag on its last edge
    // alone, which is what grows deep parent chains. A broken one scatters endpoints
    // over the whole range, shuffles weights and may drop or repeat the final flag.
    task automatic run_random_graph(input bit tidy, input int unsigned min_edges);
        int unsigned span;
        int unsigned base;
        int unsigned n_edges;
        int          wt;
        t_edge_beat  b;
        span    = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 128) : $urandom_range(2, 8);
        base    = $urandom_range(0, kuf_pkg::TABLE_DEPTH - span);
        n_edges = $urandom_range(min_edges, min_edges + 2 * span);
        if (n_edges > 40) n_edges = 40;
        wt = int'($urandom_range(0, 65535)) - 32768;
        for (int unsigned k = 0; k < n_edges; k++) begin
            if (tidy) begin
                b.va   = (kuf_pkg::VERTEX_W)'(base + $urandom_range(0, span - 1));
                b.vb   = (kuf_pkg::VERTEX_W)'(base + $urandom_range(0, span - 1));
                wt     = wt + int'($urandom_range(0, 2000));
                if (wt > 32767) wt = 32767;
                b.w    = (kuf_pkg::WEIGHT_W)'(wt);
                b.last = (k == n_edges - 1);
            end else begin
                b.va   = (kuf_pkg::VERTEX_W)'($urandom_range(0, kuf_pkg::TABLE_DEPTH - 1));
                b.vb   = (kuf_pkg::VERTEX_W)'($urandom_range(0, kuf_pkg::TABLE_DEPTH - 1));
                b.w    = (kuf_pkg::WEIGHT_W)'($urandom);
                b.last = (k == n_edges - 1) ? ($urandom_range(0, 1) == 1)
                                            : ($urandom_range(0, 7) == 0);
            end
            send_edge(b, 1'b0, 1'b0, '0);
        end
    endtask

    // Receiver: checks every result beat against the oldest verdict, then decides
    // whether ready is high for the next cycle. A long hold-off requested by the
    // stimulus is counted down here, as are the short random stalls.
    initial begin : result_sink
        int unsigned      hold_left;
        kuf_pkg::t_result got;
        kuf_pkg::t_result want;
        hold_left     = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                got.vertex_a   = res_bus.out_vertex_a;
                got.vertex_b   = res_bus.out_vertex_b;
                got.weight     = res_bus.out_weight;
                got.taken      = res_bus.taken;
                got.tree_edges = res_bus.tree_edges;
                got.graph_done = res_bus.graph_done;
                if (pending_verdicts.size() == 0) begin
                    note_failure("unexpected beat, first word", '0, 32'(got));
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.vertex_a !== want.vertex_a)
                        note_failure("out_vertex_a", 32'(want.vertex_a), 32'(got.vertex_a));
                    if (got.vertex_b !== want.vertex_b)
                        note_failure("out_vertex_b", 32'(want.vertex_b), 32'(got.vertex_b));
                    if (got.weight !== want.weight)
                        note_failure("out_weight", 32'(unsigned'(want.weight)),
                                     32'(unsigned'(got.weight)));
                    if (got.taken !== want.taken)
                        note_failure("taken", 32'(want.taken), 32'(got.taken));
                    if (got.tree_edges !== want.tree_edges)
                        note_failure("tree_edges", 32'(want.tree_edges), 32'(got.tree_edges));
                    if (got.graph_done !== want.graph_done)
                        note_failure("graph_done", 32'(want.graph_done), 32'(got.graph_done));
                end
                result_idx++;
            end
            if (hold_left != 0) begin
                res_bus.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                res_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 2);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Main sequence.
    initial begin : stimulus
        t_edge_beat b;
        // Every input to the block is known from time zero.
        i_rst_n              = 1'b0;
        edge_bus.valid       = 1'b0;
        edge_bus.vertex_a    = '0;
        edge_bus.vertex_b    = '0;
        edge_bus.edge_weight = '0;
        edge_bus.final_edge  = 1'b0;
        items_sent    = 0;
        fail_count    = 0;
        result_idx    = 0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        clear_forest();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_edge(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].typed_taken, DIRECTED_ROWS[r].typed_count);
        end

        // Random graphs, mostly well formed, with some noise mixed in.
        while (items_sent < PHASE_A_END) begin
            run_random_graph($urandom_range(0, 6) != 0, 1);
        end

        // Pressure: the receiver holds off for a long stretch while edges keep coming,
        // so the front queue fills and the input is pushed back.
        long_hold_req = 1'b1;
        run_random_graph(1'b1, 12);

        // The sender pauses until every outstanding result has been returned.
        edge_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);

        // A star graph joined through vertex 0. Each edge lengthens the chain hanging
        // from vertex 0 by one link, so the walks grow to the full table depth and the
        // count climbs to 255 before the final edge, which closes nothing.
        for (int k = 1; k < kuf_pkg::TABLE_DEPTH; k++) begin
            b.va   = '0;
            b.vb   = (kuf_pkg::VERTEX_W)'(k);
            b.w    = (kuf_pkg::WEIGHT_W)'(k);
            b.last = 1'b0;
            send_edge(b, 1'b0, 1'b0, '0);
        end
        b.va   = (kuf_pkg::VERTEX_W)'(kuf_pkg::TABLE_DEPTH - 1);
        b.vb   = '0;
        b.w    = 16'sh7FFF;
        b.last = 1'b1;
        send_edge(b, 1'b1, 1'b0, 8'd255);

        while (items_sent < PHASE_B_END) begin
            run_random_graph($urandom_range(0, 6) != 0, 1);
        end

        // Closing stretch at full rate on both sides.
        idle_on = 1'b0;
        while (items_sent < TOTAL_ITEMS) begin
            run_random_graph($urandom_range(0, 6) != 0, 1);
        end
        edge_bus.valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
